@@ rtl/gcbt_pkg.sv @@
`timescale 1ns / 1ps
package gcbt_pkg;
    localparam int MaxVertices = 8;
    localparam int MaxColors   = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

    // memory write request from the sequencer
    typedef struct packed {
        logic        we;
        logic [2:0]  addr;
        logic [31:0] dom;
        logic [2:0]  choice;
    } t_mem_req;
endpackage

@@ rtl/gcbt_stack_mem.sv @@
`timescale 1ns / 1ps
module gcbt_stack_mem (
    input  logic                i_clk,
    input  gcbt_pkg::t_mem_req  i_wr,
    input  logic [2:0]          i_rd_addr,
    output logic [31:0]         o_rd_dom,
    output logic [2:0]          o_rd_choice
);
    import gcbt_pkg::*;

    logic [34:0] r_mem [0:7];
    logic [34:0] r_rd;

    // one write port, one registered read port; a write to the entry being
    // read in the same cycle goes straight to the read data
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= {i_wr.choice, i_wr.dom};
        end
        if (i_wr.we && (i_wr.addr == i_rd_addr)) begin
            r_rd <= {i_wr.choice, i_wr.dom};
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_dom    = r_rd[31:0];
    assign o_rd_choice = r_rd[34:32];
endmodule

@@ rtl/graph_coloring_backtrack_fc.sv @@
`timescale 1ns / 1ps
// graph colouring search by depth-first backtracking with forward checking
// input channel: i_valid/o_ready carries adjacency (64 bit), vertex count,
// colour count. output channel: o_valid/i_ready carries found and colouring.
// one request is processed at a time; the level stack (remaining colour
// sets and next colour to try per level) lives in an 8-entry memory with a
// registered read port.
// each search step (a colour assignment, a backtrack or the final failure
// at level 0) reads the level entry, then evaluates and writes back.
// the result sits in an output register until taken; a new request is
// accepted from the cycle after the previous result has been taken.
// reset is synchronous and active low; it returns the sequencer to idle and
// drops o_valid. the memory needs no clearing since every level entry is
// written before it is read.
module graph_coloring_backtrack_fc #(
    parameter int MAX_VERTICES = gcbt_pkg::MaxVertices,
    parameter int MAX_COLORS   = gcbt_pkg::MaxColors
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_adjacency,
    input  logic [3:0]  i_vertex_count,
    input  logic [2:0]  i_color_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [15:0] o_coloring
);
    import gcbt_pkg::*;

    t_state      r_state, n_state;
    logic [63:0] r_adj;
    logic [3:0]  r_n;
    logic [3:0]  r_lvl, n_lvl;
    logic [15:0] r_colors, n_colors;
    logic [7:0]  r_flags, n_flags;
    logic        r_found, n_found;
    logic        r_ovalid, n_ovalid;
    logic [15:0] r_ocol, n_ocol;
    t_mem_req    w_wr;
    t_mem_req    w_wr_mux;
    logic [2:0]  w_rd_addr;
    logic [31:0] w_rd_dom;
    logic [2:0]  w_rd_choice;

    // saturated counts and initial domains
    logic [3:0]  w_n;
    logic [2:0]  w_k;
    logic [31:0] w_init;
    logic [7:0]  w_use;
    always_comb begin
        w_n = (i_vertex_count > 4'(MAX_VERTICES)) ? 4'(MAX_VERTICES) : i_vertex_count;
        w_k = (i_color_count > 3'(MAX_COLORS)) ? 3'(MAX_COLORS) : i_color_count;
        w_init = '0;
        for (int v = 0; v < 8; v++) begin
            if (4'(v) < w_n) begin
                w_init[4*v +: 4] = 4'((5'd1 << w_k) - 5'd1);
            end
        end
    end

    gcbt_stack_mem u_mem (
        .i_clk       (i_clk),
        .i_wr        (w_wr_mux),
        .i_rd_addr   (w_rd_addr),
        .o_rd_dom    (w_rd_dom),
        .o_rd_choice (w_rd_choice)
    );

    assign w_rd_addr = r_lvl[2:0];

    // colour selection at the current level
    logic [7:0]  w_nbrs;
    logic [3:0]  w_dom, w_block, w_cand;
    logic        w_ok;
    logic [1:0]  w_c;
    logic [31:0] w_fc;
    always_comb begin
        w_use = 8'((9'd1 << r_n) - 9'd1);
        w_nbrs = r_adj[8*r_lvl[2:0] +: 8] & w_use & ~(8'd1 << r_lvl[2:0]);
        w_dom = w_rd_dom[4*r_lvl[2:0] +: 4];
        w_block = '0;
        for (int j = 0; j < 8; j++) begin
            if (w_nbrs[j] && r_flags[j]) begin
                w_block[r_colors[2*j +: 2]] = 1'b1;
            end
        end
        w_cand = w_dom & ~w_block;
        for (int c = 0; c < 4; c++) begin
            if (3'(c) < w_rd_choice && c < MAX_COLORS) w_cand[c] = 1'b0;
            if (c >= MAX_COLORS) w_cand[c] = 1'b0;
        end
        w_ok = |w_cand;
        w_c = w_cand[0] ? 2'd0 : w_cand[1] ? 2'd1 : w_cand[2] ? 2'd2 : 2'd3;
        w_fc = w_rd_dom;
        for (int j = 0; j < 8; j++) begin
            if (w_nbrs[j] && ($countones(w_rd_dom[4*j +: 4]) > 1)) begin
                w_fc[4*j + int'(w_c)] = 1'b0;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid && !r_ovalid) n_state = ST_READ;
            ST_READ: n_state = (r_lvl >= r_n) ? ST_DONE : ST_EVAL;
            ST_EVAL: n_state = (!w_ok && r_lvl == 4'd0) ? ST_DONE : ST_READ;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory writes
    always_comb begin
        n_lvl = r_lvl;
        n_colors = r_colors;
        n_flags = r_flags;
        n_found = r_found;
        n_ovalid = r_ovalid && !i_ready;
        n_ocol = r_ocol;
        w_wr = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    n_lvl = '0;
                    n_colors = '0;
                    n_flags = '0;
                    w_wr.we = 1'b1;
                    w_wr.addr = '0;
                    w_wr.dom = w_init;
                    w_wr.choice = '0;
                end
            end
            ST_READ: begin
                if (r_lvl >= r_n) n_found = 1'b1;
            end
            ST_EVAL: begin
                if (w_ok) begin
                    n_colors[2*r_lvl[2:0] +: 2] = w_c;
                    n_flags[r_lvl[2:0]] = 1'b1;
                    n_lvl = r_lvl + 4'd1;
                    // record next colour for this level
                    w_wr.we = 1'b1;
                    w_wr.addr = r_lvl[2:0];
                    w_wr.dom = w_rd_dom;
                    w_wr.choice = 3'(w_c) + 3'd1;
                end else if (r_lvl == 4'd0) begin
                    n_found = 1'b0;
                end else begin
                    n_lvl = r_lvl - 4'd1;
                    n_flags[r_lvl[2:0] - 3'd1] = 1'b0;
                    n_colors[2*(r_lvl[2:0] - 3'd1) +: 2] = 2'd0;
                end
            end
            ST_DONE: begin
                n_ovalid = 1'b1;
                n_ocol = r_found ? r_colors : 16'd0;
            end
            default: ;
        endcase
    end

    // child level entry written in a second port slot: store on the cycle after
    logic        r_child_we;
    logic [2:0]  r_child_addr;
    logic [31:0] r_child_dom;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_child_we <= 1'b0;
        end else begin
            r_child_we <= (r_state == ST_EVAL) && w_ok && (r_lvl + 4'd1 < r_n);
        end
        r_child_addr <= r_lvl[2:0] + 3'd1;
        r_child_dom  <= w_fc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            // found is held with the result until the next request starts
            r_found <= (r_state == ST_IDLE && i_valid && !r_ovalid) ? 1'b0 : n_found;
        end
        r_lvl <= n_lvl;
        r_colors <= n_colors;
        r_flags <= n_flags;
        r_ocol <= n_ocol;
        if (r_state == ST_IDLE && i_valid && !r_ovalid) begin
            r_adj <= i_adjacency;
            r_n <= w_n;
        end
    end

    // the child write lands during the following read cycle, which reads
    // the same child address; the memory passes it through to the read data
    always_comb begin
        w_wr_mux = w_wr;
        if (r_child_we) begin
            w_wr_mux.we = 1'b1;
            w_wr_mux.addr = r_child_addr;
            w_wr_mux.dom = r_child_dom;
            w_wr_mux.choice = 3'd0;
        end
    end

    assign o_ready    = (r_state == ST_IDLE) && !r_ovalid;
    assign o_valid    = r_ovalid;
    assign o_found    = r_found && r_ovalid;
    assign o_coloring = r_ocol;
endmodule
